// ===== rtl/core/hgwe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgwe_pkg
// Shared types, constants and helpers of the Hermite-Gauss level evaluator.
// ----------------------------------------------------------------------------
package hgwe_pkg;

	localparam int LEVEL_CNT    = 6;
	localparam int HORNER_STEPS = 12;
	localparam int RECIP_SHIFT  = 38;
	localparam int PIPE_LAST    = 63;

	typedef logic signed [63:0] q64_t;
	typedef logic signed [67:0] wide_t;
	typedef logic [6:0] shamt_t;
	typedef logic [2:0] cfg_idx_t;
	typedef logic [38:0] recip_t;
	typedef logic [LEVEL_CNT-1:0][63:0] hvec_t;

	localparam cfg_idx_t REG_PREFACTOR      = 3'd0;
	localparam cfg_idx_t REG_HERMITE_SCALE  = 3'd1;
	localparam cfg_idx_t REG_GAUSS_COEFF    = 3'd2;
	localparam cfg_idx_t REG_ENERGY_QUANTUM = 3'd3;
	localparam cfg_idx_t REG_HALF_SPRING    = 3'd4;

	localparam logic signed [31:0] RST_PREFACTOR      = 32'sd158193;
	localparam logic signed [31:0] RST_HERMITE_SCALE  = 32'sd676810;
	localparam logic signed [31:0] RST_GAUSS_COEFF    = -32'sd3494838;
	localparam logic signed [31:0] RST_ENERGY_QUANTUM = 32'sd2819097;
	localparam logic signed [31:0] RST_HALF_SPRING    = 32'sd150331591;

	localparam q64_t  LIM_Q     = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam wide_t LIM_W     = 68'sh3FFF_FFFF_FFFF_FFFF;
	localparam q64_t  ONE_Q32   = 64'sh1_0000_0000;
	localparam q64_t  LOG2E_Q32 = 64'sd6196328019;
	localparam q64_t  LN2_Q32   = 64'sd2977044472;

	localparam shamt_t SH_0  = 7'd0;
	localparam shamt_t SH_16 = 7'd16;
	localparam shamt_t SH_31 = 7'd31;
	localparam shamt_t SH_32 = 7'd32;

	localparam q64_t NORM_TAB [LEVEL_CNT] = '{
		64'sd4294967296, 64'sd3037000500, 64'sd1518500250,
		64'sd619925131, 64'sd219176632, 64'sd69309737
	};

	// ceil(2^38 / n) for n = 12 down to 1
	localparam recip_t HORNER_RECIP [HORNER_STEPS] = '{
		39'(((64'd1 << RECIP_SHIFT) + 64'd11) / 64'd12),
		39'(((64'd1 << RECIP_SHIFT) + 64'd10) / 64'd11),
		39'(((64'd1 << RECIP_SHIFT) + 64'd9) / 64'd10),
		39'(((64'd1 << RECIP_SHIFT) + 64'd8) / 64'd9),
		39'(((64'd1 << RECIP_SHIFT) + 64'd7) / 64'd8),
		39'(((64'd1 << RECIP_SHIFT) + 64'd6) / 64'd7),
		39'(((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6),
		39'(((64'd1 << RECIP_SHIFT) + 64'd4) / 64'd5),
		39'(((64'd1 << RECIP_SHIFT) + 64'd3) / 64'd4),
		39'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3),
		39'(((64'd1 << RECIP_SHIFT) + 64'd1) / 64'd2),
		39'(64'd1 << RECIP_SHIFT)
	};

	function automatic q64_t clamp_q(input wide_t v);
		if (v > LIM_W) begin
			return LIM_Q;
		end
		if (v < -LIM_W) begin
			return -LIM_Q;
		end
		return v[63:0];
	endfunction

	function automatic q64_t scale_clamp(input q64_t h, input logic [3:0] c);
		wide_t hw;
		wide_t cw;
		hw = 68'(h);
		cw = 68'($signed({1'b0, c}));
		return clamp_q(hw * cw);
	endfunction

	function automatic logic signed [31:0] sat32(input wide_t v);
		if (v > 68'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end
		if (v < -68'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

endpackage

// ===== rtl/core/hgwe_mulq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgwe_mulq
// Two-stage signed multiply with round-to-nearest on the magnitude, a right
// shift by sh and clamping to the internal range.
// ----------------------------------------------------------------------------
module hgwe_mulq (
	input  logic            clk,
	input  logic            en,
	input  hgwe_pkg::q64_t  a,
	input  hgwe_pkg::q64_t  b,
	input  hgwe_pkg::shamt_t sh,
	output hgwe_pkg::q64_t  p
);
	import hgwe_pkg::*;

	logic [61:0]  mag_a, mag_b;
	logic         neg_s1;
	logic [63:0]  pp00_s1;
	logic [61:0]  pp01_s1, pp10_s1;
	logic [59:0]  pp11_s1;
	logic [124:0] full, rnd, shifted;
	logic [63:0]  mag;
	q64_t         p_s2;

	assign mag_a = a[63] ? 62'(-a) : a[61:0];
	assign mag_b = b[63] ? 62'(-b) : b[61:0];

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= a[63] ^ b[63];
			pp00_s1 <= mag_a[31:0] * mag_b[31:0];
			pp01_s1 <= mag_a[31:0] * mag_b[61:32];
			pp10_s1 <= mag_a[61:32] * mag_b[31:0];
			pp11_s1 <= mag_a[61:32] * mag_b[61:32];
		end
	end

	always_comb begin
		rnd     = (sh == SH_0) ? '0 : (125'(1) << (sh - 7'd1));
		full    = 125'(pp00_s1) + (125'(pp01_s1) << 32) + (125'(pp10_s1) << 32)
			+ (125'(pp11_s1) << 64) + rnd;
		shifted = full >> sh;
		mag     = (shifted > 125'(LIM_Q)) ? 64'(LIM_Q) : shifted[63:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= neg_s1 ? -$signed(mag) : $signed(mag);
		end
	end

	assign p = p_s2;

endmodule

// ===== rtl/core/hermite_gauss_wavefunction_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hermite_gauss_wavefunction_eval
// Harmonic potential and oscillator levels 0 to 5 for one position sample.
// ----------------------------------------------------------------------------
// Usage:
//   position (signed Q8.16) enters on in_valid/in_ready; one result with
//   potential and level0..level5 (signed Q16.16, saturating) leaves on
//   out_valid/out_ready. Registers are written through cfg_valid, cfg_index
//   and cfg_data; the user must write them only while no transaction is
//   in flight; the block itself does not enforce this. cfg_ready is always
//   high and indexes above four are ignored. A new sample is taken every
//   cycle whenever in_ready is high; the 64-stage pipeline consists of the
//   input register, squaring, two multiply stages per fixed-point product,
//   twelve Horner steps for the exponential, Hermite recurrence, scaling
//   and final rounding.
//   If out_ready is low while a result waits, every stage holds and in_ready
//   falls; nothing is dropped or repeated. Reset empties the pipeline and
//   loads the default register values.
// ----------------------------------------------------------------------------
module hermite_gauss_wavefunction_eval (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [23:0]       position,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [31:0]       potential,
	output logic signed [31:0]       level0,
	output logic signed [31:0]       level1,
	output logic signed [31:0]       level2,
	output logic signed [31:0]       level3,
	output logic signed [31:0]       level4,
	output logic signed [31:0]       level5,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  hgwe_pkg::cfg_idx_t       cfg_index,
	input  logic signed [31:0]       cfg_data
);
	import hgwe_pkg::*;

	logic                 adv;
	logic [PIPE_LAST:0]   vld;
	logic signed [31:0]   pref_q, hs_q, gc_q, eq_q, hk_q;
	logic signed [23:0]   pos_s0;
	logic signed [47:0]   x2_s1;
	logic signed [55:0]   a_s1;
	q64_t                 pot_m, e_m, y_m, z_m;
	logic signed [31:0]   pot_s4;
	logic signed [31:0]   pot_dl [PIPE_LAST-4];
	logic signed [31:0]   k_dl [2];
	logic signed [55:0]   a_dl [43];
	logic [31:0]          hz [HORNER_STEPS+1];
	q64_t                 hsv [HORNER_STEPS+1];
	logic signed [31:0]   hk [HORNER_STEPS+1];
	logic [34:0]          s_fin;
	logic signed [31:0]   k_fin;
	logic [5:0]           nk;
	logic [63:0]          shl, shr;
	q64_t                 ex_c, ex_s56;
	hvec_t                hin [2:LEVEL_CNT];
	logic signed [55:0]   ain [2:LEVEL_CNT];
	logic signed [31:0]   lvl_s63 [LEVEL_CNT];

	assign adv       = !vld[PIPE_LAST] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld[PIPE_LAST];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (adv) begin
			vld <= {vld[PIPE_LAST-1:0], in_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pref_q <= RST_PREFACTOR;
			hs_q   <= RST_HERMITE_SCALE;
			gc_q   <= RST_GAUSS_COEFF;
			eq_q   <= RST_ENERGY_QUANTUM;
			hk_q   <= RST_HALF_SPRING;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PREFACTOR:      pref_q <= cfg_data;
				REG_HERMITE_SCALE:  hs_q   <= cfg_data;
				REG_GAUSS_COEFF:    gc_q   <= cfg_data;
				REG_ENERGY_QUANTUM: eq_q   <= cfg_data;
				REG_HALF_SPRING:    hk_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s0 <= position;
			x2_s1  <= pos_s0 * pos_s0;
			a_s1   <= hs_q * pos_s0;
		end
	end

	// potential
	hgwe_mulq u_pot (.clk(clk), .en(adv), .a(64'(hk_q)), .b(64'(x2_s1)), .sh(SH_32),
		.p(pot_m));

	always_ff @(posedge clk) begin
		if (adv) begin
			pot_s4    <= sat32(68'(pot_m));
			pot_dl[0] <= pot_s4;
			for (int i = 1; i < PIPE_LAST - 4; i++) begin
				pot_dl[i] <= pot_dl[i-1];
			end
		end
	end

	// exponent and base-two split
	hgwe_mulq u_gexp (.clk(clk), .en(adv), .a(64'(gc_q)), .b(64'(x2_s1)), .sh(SH_16),
		.p(e_m));
	hgwe_mulq u_log2e (.clk(clk), .en(adv), .a(e_m), .b(LOG2E_Q32), .sh(SH_32), .p(y_m));
	hgwe_mulq u_ln2 (.clk(clk), .en(adv), .a({32'b0, y_m[31:0]}), .b(LN2_Q32), .sh(SH_32),
		.p(z_m));

	always_ff @(posedge clk) begin
		if (adv) begin
			k_dl[0] <= y_m[63:32];
			k_dl[1] <= k_dl[0];
		end
	end

	assign hz[0]  = z_m[31:0];
	assign hsv[0] = ONE_Q32;
	assign hk[0]  = k_dl[1];

	// horner series for 2^f
	for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
		q64_t        v_m;
		logic [31:0] z_d [4];
		logic signed [31:0] k_d [4];
		logic [72:0] prod_s3;
		q64_t        s_s4;

		hgwe_mulq u_step (.clk(clk), .en(adv), .a({32'b0, hz[j]}), .b(hsv[j]), .sh(SH_32),
			.p(v_m));

		always_ff @(posedge clk) begin
			if (adv) begin
				z_d[0] <= hz[j];
				k_d[0] <= hk[j];
				for (int i = 1; i < 4; i++) begin
					z_d[i] <= z_d[i-1];
					k_d[i] <= k_d[i-1];
				end
				prod_s3 <= v_m[33:0] * HORNER_RECIP[j];
				s_s4    <= ONE_Q32 + $signed(64'(prod_s3 >> RECIP_SHIFT));
			end
		end

		assign hz[j+1]  = z_d[3];
		assign hk[j+1]  = k_d[3];
		assign hsv[j+1] = s_s4;
	end

	always_comb begin
		s_fin = hsv[HORNER_STEPS][34:0];
		k_fin = hk[HORNER_STEPS];
		nk    = 6'(-k_fin);
		shl   = 64'(s_fin) << k_fin[4:0];
		shr   = (64'(s_fin) + (64'd1 << (nk - 6'd1))) >> nk;
		if (!k_fin[31]) begin
			if (k_fin > 32'sd29) begin
				ex_c = LIM_Q;
			end else if (shl > 64'(LIM_Q)) begin
				ex_c = LIM_Q;
			end else begin
				ex_c = $signed(shl);
			end
		end else if (k_fin < -32'sd40) begin
			ex_c = '0;
		end else begin
			ex_c = $signed(shr);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ex_s56   <= ex_c;
			a_dl[0]  <= a_s1;
			for (int i = 1; i < 43; i++) begin
				a_dl[i] <= a_dl[i-1];
			end
		end
	end

	// hermite recurrence
	always_comb begin
		hin[2]    = '0;
		hin[2][0] = ONE_Q32;
		hin[2][1] = 64'(2 * 64'(a_dl[42]));
		ain[2]    = a_dl[42];
	end

	for (genvar m = 2; m < LEVEL_CNT; m++) begin : g_herm
		q64_t               pm;
		hvec_t              hd [2];
		logic signed [55:0] ad [2];
		hvec_t              hout_s3;
		hvec_t              hnxt;
		logic signed [55:0] aout_s3;
		q64_t               sub;

		hgwe_mulq u_rec (.clk(clk), .en(adv), .a(64'(ain[m])), .b(hin[m][m-1]), .sh(SH_31),
			.p(pm));

		assign sub = scale_clamp($signed(hd[1][m-2]), 4'(2 * (m - 1)));

		always_comb begin
			hnxt    = hd[1];
			hnxt[m] = clamp_q(68'(pm) - 68'(sub));
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				hd[0]      <= hin[m];
				hd[1]      <= hd[0];
				ad[0]      <= ain[m];
				ad[1]      <= ad[0];
				hout_s3    <= hnxt;
				aout_s3    <= ad[1];
			end
		end

		assign hin[m+1] = hout_s3;
		assign ain[m+1] = aout_s3;
	end

	// level scaling and energy offset
	for (genvar n = 0; n < LEVEL_CNT; n++) begin : g_lvl
		localparam wide_t EN_MUL = 68'((2 * n + 1) * 32768);
		q64_t  t1, t2, t3;
		wide_t sum, rnd;

		hgwe_mulq u_gauss (.clk(clk), .en(adv), .a(hin[LEVEL_CNT][n]), .b(ex_s56),
			.sh(SH_32), .p(t1));
		hgwe_mulq u_norm (.clk(clk), .en(adv), .a(t1), .b(NORM_TAB[n]), .sh(SH_32), .p(t2));
		hgwe_mulq u_pref (.clk(clk), .en(adv), .a(t2), .b(64'(pref_q)), .sh(SH_16), .p(t3));

		always_comb begin
			sum = 68'(clamp_q(68'(t3) + 68'(eq_q) * EN_MUL));
			rnd = (sum + 68'sd32768) >>> 16;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				lvl_s63[n] <= sat32(rnd);
			end
		end
	end

	assign potential = pot_dl[PIPE_LAST-5];
	assign level0    = lvl_s63[0];
	assign level1    = lvl_s63[1];
	assign level2    = lvl_s63[2];
	assign level3    = lvl_s63[3];
	assign level4    = lvl_s63[4];
	assign level5    = lvl_s63[5];

endmodule

// ===== tb/hermite_gauss_wavefunction_eval_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hermite_gauss_wavefunction_eval_test
// Drives position samples through the level evaluator under random idling and
// a long output stall, predicts potential and level0..level5 in fixed point,
// and compares every result transaction in order. Registers are rewritten
// between phases, extremes included.
// ----------------------------------------------------------------------------
module hermite_gauss_wavefunction_eval_test;
	import hgwe_pkg::*;

	localparam longint LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam int LATENCY = 63;

	typedef struct {
		logic signed [31:0] potential;
		logic signed [31:0] level [6];
	} levels_t;

	class level_scoreboard;
		levels_t pending [$];
		longint sreg [5];
		int errors;
		int checked;

		function void load_defaults();
			sreg[REG_PREFACTOR] = RST_PREFACTOR;
			sreg[REG_HERMITE_SCALE] = RST_HERMITE_SCALE;
			sreg[REG_GAUSS_COEFF] = RST_GAUSS_COEFF;
			sreg[REG_ENERGY_QUANTUM] = RST_ENERGY_QUANTUM;
			sreg[REG_HALF_SPRING] = RST_HALF_SPRING;
		endfunction

		function void write_reg(cfg_idx_t idx, logic signed [31:0] val);
			if (idx <= REG_HALF_SPRING) begin
				sreg[idx] = val;
			end
		endfunction

		function longint clip(logic signed [127:0] v);
			if (v > LIM) begin
				return LIM;
			end
			if (v < -LIM) begin
				return -LIM;
			end
			return longint'(v);
		endfunction

		function longint add_sat(longint a, longint b);
			logic signed [127:0] s;
			s = 128'(clip(a)) + 128'(clip(b));
			return clip(s);
		endfunction

		// rounded on magnitude, ties away from zero
		function longint mul_round(longint a, longint b, int sh);
			logic [127:0] ua, ub, p;
			logic neg;
			a = clip(a);
			b = clip(b);
			neg = (a < 0) != (b < 0);
			ua = a < 0 ? -128'(a) : 128'(a);
			ub = b < 0 ? -128'(b) : 128'(b);
			p = ua * ub;
			if (sh > 0) begin
				p = (p + (128'd1 << (sh - 1))) >> sh;
			end
			if (p > 128'(LIM)) begin
				p = 128'(LIM);
			end
			return neg ? -longint'(p) : longint'(p);
		endfunction

		function longint floor_sh(longint v, int sh);
			return v >>> sh;
		endfunction

		function logic signed [31:0] to32(longint v);
			if (v > 64'sd2147483647) begin
				return 32'sh7FFF_FFFF;
			end
			if (v < -64'sd2147483648) begin
				return 32'sh8000_0000;
			end
			return v[31:0];
		endfunction

		function longint gauss_exp(longint e);
			longint y, k, f, z, s;
			y = mul_round(e, LOG2E_Q32, 32);
			k = floor_sh(y, 32);
			f = y - (k <<< 32);
			z = mul_round(f, LN2_Q32, 32);
			s = ONE_Q32;
			for (int n = 12; n >= 1; n--) begin
				s = add_sat(ONE_Q32, mul_round(z, s, 32) / n);
			end
			if (k >= 0) begin
				if (k > 29) begin
					return LIM;
				end
				return clip(128'(s) <<< k);
			end
			if (k < -40) begin
				return 0;
			end
			return longint'((64'(s) + (64'd1 << (-k - 1))) >> (-k));
		endfunction

		function void note_sample(logic signed [23:0] pos);
			levels_t r;
			longint x, x2, a, ex, t, en;
			longint h [6];
			x = pos;
			x2 = x * x;
			a = sreg[REG_HERMITE_SCALE] * x;
			r.potential = to32(mul_round(sreg[REG_HALF_SPRING], x2, 32));
			h[0] = ONE_Q32;
			h[1] = mul_round(a, 2, 0);
			for (int n = 2; n < 6; n++) begin
				h[n] = add_sat(mul_round(a, h[n-1], 31), -mul_round(h[n-2], 2 * (n - 1), 0));
			end
			ex = gauss_exp(mul_round(sreg[REG_GAUSS_COEFF], x2, 16));
			for (int n = 0; n < 6; n++) begin
				t = mul_round(h[n], ex, 32);
				t = mul_round(t, NORM_TAB[n], 32);
				t = mul_round(t, sreg[REG_PREFACTOR], 16);
				en = sreg[REG_ENERGY_QUANTUM] * longint'(2 * n + 1) * 32768;
				t = add_sat(t, en);
				r.level[n] = to32(floor_sh(t + 32768, 16));
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic signed [31:0] pot, logic signed [31:0] lv [6]);
			levels_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected result transaction, potential %0d", $time, pot);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (pot !== e.potential) begin
				$display("%0t potential expected %0d actual %0d", $time, e.potential, pot);
				errors++;
			end
			for (int n = 0; n < 6; n++) begin
				if (lv[n] !== e.level[n]) begin
					$display("%0t level%0d expected %0d actual %0d", $time, n, e.level[n], lv[n]);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	logic signed [23:0] position;
	logic signed [31:0] potential, level0, level1, level2, level3, level4, level5;
	cfg_idx_t cfg_index;
	logic signed [31:0] cfg_data;

	level_scoreboard sb;
	int idle_pct;
	int hold_off;
	int sent;

	hermite_gauss_wavefunction_eval dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .position(position),
		.out_valid(out_valid), .out_ready(out_ready),
		.potential(potential), .level0(level0), .level1(level1), .level2(level2),
		.level3(level3), .level4(level4), .level5(level5),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("status: fail");
		$finish;
	end

	// output side: sample at rising edge, stall at falling edge
	always @(posedge clk) begin
		logic signed [31:0] lv [6];
		if (arst_n && out_valid && out_ready) begin
			lv = '{level0, level1, level2, level3, level4, level5};
			sb.check_result(potential, lv);
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	task automatic send_sample(logic signed [23:0] pos);
		while (($urandom_range(99) < idle_pct)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		position <= pos;
		do begin
			@(posedge clk);
		end while (!in_ready);
		sb.note_sample(pos);
		sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic signed [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() > 0) begin
			@(negedge clk);
		end
		repeat (LATENCY + 8) @(negedge clk);
	endtask

	function automatic logic signed [23:0] rand_position();
		case ($urandom_range(3))
			0: return 24'($urandom);
			1: return 24'($signed($urandom_range(196608)) - 98304);
			2: return 24'($signed($urandom_range(65536)) - 32768);
			default: return $urandom_range(1) ? 24'sh7FFFFF - 24'($urandom_range(255))
				: 24'sh800000 + 24'($urandom_range(255));
		endcase
	endfunction

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) begin
			idle_pct = (i >= count / 3 && i < count / 2) ? 0 : 23;
			send_sample(rand_position());
		end
		drain();
	endtask

	initial begin
		logic signed [23:0] corner [$];
		sb = new();
		sb.load_defaults();
		in_valid = 1'b0;
		position = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_PREFACTOR;
		cfg_data = '0;
		hold_off = 0;
		idle_pct = 23;
		sent = 0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		corner = '{24'sd0, 24'sd1, -24'sd1, 24'sd65536, -24'sd65536, 24'sh7FFFFF,
			24'sh800000, 24'sd16384, -24'sd16384, 24'sd32768, 24'sd131072,
			24'sh555555, 24'shAAAAAA, 24'sd400000, -24'sd400000};
		foreach (corner[i]) begin
			send_sample(corner[i]);
		end
		// long receiver stall while input keeps coming
		hold_off = 200;
		for (int i = 0; i < 100; i++) begin
			idle_pct = 0;
			send_sample(rand_position());
		end
		idle_pct = 23;
		drain();

		random_phase(500);

		// extremes, including an ignored index
		write_reg(REG_PREFACTOR, 32'sh7FFF_FFFF);
		write_reg(REG_HERMITE_SCALE, 32'sh8000_0000);
		write_reg(REG_GAUSS_COEFF, 32'sh7FFF_FFFF);
		write_reg(REG_ENERGY_QUANTUM, 32'sh8000_0000);
		write_reg(REG_HALF_SPRING, 32'sh7FFF_FFFF);
		write_reg(cfg_idx_t'(7), 32'sd12345);
		foreach (corner[i]) begin
			send_sample(corner[i]);
		end
		random_phase(200);

		write_reg(REG_PREFACTOR, 32'sh8000_0000);
		write_reg(REG_HERMITE_SCALE, 32'sh7FFF_FFFF);
		write_reg(REG_GAUSS_COEFF, 32'sh8000_0000);
		write_reg(REG_ENERGY_QUANTUM, 32'sh7FFF_FFFF);
		write_reg(REG_HALF_SPRING, 32'sh8000_0000);
		random_phase(200);

		write_reg(REG_PREFACTOR, 32'sd0);
		write_reg(REG_HERMITE_SCALE, 32'sd0);
		write_reg(REG_GAUSS_COEFF, 32'sd0);
		write_reg(REG_ENERGY_QUANTUM, 32'sd0);
		write_reg(REG_HALF_SPRING, 32'sd0);
		random_phase(100);

		for (int p = 0; p < 4; p++) begin
			write_reg(REG_PREFACTOR, $urandom);
			write_reg(REG_HERMITE_SCALE, $urandom);
			write_reg(REG_GAUSS_COEFF, -$signed(32'($urandom_range(8000000))));
			write_reg(REG_ENERGY_QUANTUM, $urandom);
			write_reg(REG_HALF_SPRING, $urandom);
			write_reg(cfg_idx_t'($urandom_range(7)), $urandom);
			random_phase(160);
		end

		$display("run sent %0d positions and compared %0d result transactions", sent, sb.checked);
		$display("over default, extreme, zero and random register settings");
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
